// File: rtl/core/i2cgc_pkg.sv
package i2cgc_pkg;

	// event codes
	localparam logic [1:0] OP_STOP = 2'd0;
	localparam logic [1:0] OP_RX_BYTE = 2'd1;
	localparam logic [1:0] OP_TX_REQ = 2'd2;

	// bus phases
	localparam logic [1:0] PHASE_IDLE = 2'd0;
	localparam logic [1:0] PHASE_RX_FIRST = 2'd1;
	localparam logic [1:0] PHASE_RX = 2'd2;
	localparam logic [1:0] PHASE_TX = 2'd3;

	// general-call commands
	localparam logic [7:0] CMD_NEW_ADDR = 8'h00;
	localparam logic [7:0] CMD_RESET_ALL = 8'h01;
	localparam logic [7:0] CMD_VERIFY_KEY = 8'h02;
	localparam logic [7:0] CMD_UPDATE_KEY = 8'h03;

	// configuration register indexes
	localparam int CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_STARTUP_ADDRESS = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STARTUP_KEY = 8'd1;
	localparam int CFG_DATA_W = 16;

	localparam logic [1:0] SEEN_MAX = 2'd3;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] rx_byte;
		logic general_call;
		logic arbitration_won;
	} event_t;

	typedef struct packed {
		logic address_reload;
		logic [7:0] own_address;
		logic nack;
		logic [15:0] project_key;
		logic reg_write;
		logic read_request;
		logic reg_target;
		logic signed [7:0] reg_index;
		logic [7:0] reg_data;
	} result_t;

	typedef struct packed {
		logic [1:0] bus_phase;
		logic [7:0] command_code;
		logic [1:0] bytes_seen;
		logic [7:0] low_key_byte;
		logic address_pending;
		logic [7:0] address_value;
		logic [15:0] key_value;
		logic [7:0] pointer_value;
	} state_t;

endpackage

// File: rtl/core/i2cgc_if.sv
interface i2cgc_evt_if;
	logic valid;
	logic ready;
	i2cgc_pkg::event_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface i2cgc_res_if;
	logic valid;
	logic ready;
	i2cgc_pkg::result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface i2cgc_cfg_if;
	logic valid;
	logic ready;
	logic [i2cgc_pkg::CFG_IDX_W-1:0] index;
	logic [i2cgc_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/i2cgc_event_logic.sv
module i2cgc_event_logic (
	input  i2cgc_pkg::state_t  st,
	input  i2cgc_pkg::event_t  evt,
	output i2cgc_pkg::state_t  nxt,
	output i2cgc_pkg::result_t res
);

	logic first;
	logic [1:0] prior_seen;
	logic [15:0] rx_key;
	logic ptr_device;

	assign first = (st.bus_phase == i2cgc_pkg::PHASE_IDLE);
	assign prior_seen = st.bytes_seen;
	assign rx_key = {evt.rx_byte, st.low_key_byte};
	// device registers: pointer from 2 up to 127 as signed
	assign ptr_device = !st.pointer_value[7] && (st.pointer_value[6:1] != 6'd0);

	// next state and event flags
	always_comb begin
		nxt = st;
		res = '0;
		unique case (evt.operation)
			i2cgc_pkg::OP_STOP: begin
				nxt.bus_phase = i2cgc_pkg::PHASE_IDLE;
				if (st.address_pending) begin
					nxt.address_pending = 1'b0;
					res.address_reload = 1'b1;
				end
			end
			i2cgc_pkg::OP_RX_BYTE: begin
				nxt.bus_phase = first ? i2cgc_pkg::PHASE_RX_FIRST : i2cgc_pkg::PHASE_RX;
				if (evt.general_call) begin
					if (first) begin
						nxt.bytes_seen = 2'd1;
						nxt.command_code = evt.rx_byte;
						if (evt.rx_byte == i2cgc_pkg::CMD_RESET_ALL) begin
							nxt.address_value = 8'd0;
							nxt.address_pending = 1'b1;
							nxt.key_value = 16'd0;
						end
					end else begin
						if (st.bytes_seen != i2cgc_pkg::SEEN_MAX) begin
							nxt.bytes_seen = st.bytes_seen + 2'd1;
						end
						case (st.command_code)
							i2cgc_pkg::CMD_NEW_ADDR: begin
								// an address already held locks out reassignment
								if (!st.address_pending && st.address_value != 8'd0) begin
									res.nack = 1'b1;
								end else if (prior_seen >= 2'd2) begin
									res.nack = 1'b0;
								end else if (evt.arbitration_won) begin
									nxt.address_pending = 1'b1;
									nxt.address_value = evt.rx_byte;
								end else begin
									res.nack = 1'b1;
								end
							end
							i2cgc_pkg::CMD_VERIFY_KEY: begin
								if (prior_seen == 2'd1) begin
									nxt.low_key_byte = evt.rx_byte;
								end else if (prior_seen == 2'd2 && rx_key != st.key_value) begin
									nxt.address_value = 8'd0;
									nxt.address_pending = 1'b1;
									nxt.key_value = rx_key;
								end
							end
							i2cgc_pkg::CMD_UPDATE_KEY: begin
								if (prior_seen == 2'd1) begin
									nxt.low_key_byte = evt.rx_byte;
								end else if (prior_seen == 2'd2) begin
									nxt.key_value = rx_key;
								end
							end
							default: begin
							end
						endcase
					end
				end else if (first) begin
					nxt.pointer_value = evt.rx_byte;
				end else begin
					res.reg_write = 1'b1;
					res.reg_target = ptr_device;
					res.reg_index = st.pointer_value;
					res.reg_data = evt.rx_byte;
				end
			end
			i2cgc_pkg::OP_TX_REQ: begin
				nxt.bus_phase = i2cgc_pkg::PHASE_TX;
				res.read_request = 1'b1;
				res.reg_target = ptr_device;
				res.reg_index = st.pointer_value;
			end
			default: begin
			end
		endcase
		res.own_address = nxt.address_value;
		res.project_key = nxt.key_value;
	end

endmodule

// File: rtl/core/i2cgc_core_regs.sv
module i2cgc_core_regs (
	input  logic                clk,
	input  logic                arst_n,
	i2cgc_evt_if.sink           evt,
	i2cgc_res_if.source         res,
	i2cgc_cfg_if.sink           cfg,
	output i2cgc_pkg::state_t   st,
	output i2cgc_pkg::event_t   evt_s1,
	input  i2cgc_pkg::state_t   nxt,
	input  i2cgc_pkg::result_t  res_comb
);

	logic valid_s1;
	logic valid_s2;
	logic advance;
	logic cfg_wr;
	i2cgc_pkg::state_t state_q;
	i2cgc_pkg::result_t res_s2;

	// stage 1 moves into the result register when it is free or being drained
	assign advance = valid_s1 && (!valid_s2 || res.ready);
	assign evt.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;
	assign cfg_wr = cfg.valid;
	assign st = state_q;
	assign res.valid = valid_s2;
	assign res.data = res_s2;

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (evt.ready) begin
				valid_s1 <= evt.valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (res.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// input and result payload
	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			evt_s1 <= evt.data;
		end
		if (advance) begin
			res_s2 <= res_comb;
		end
	end

	// block state, with configuration loads of address and key
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else begin
			if (advance) begin
				state_q <= nxt;
			end
			if (cfg_wr && cfg.index == i2cgc_pkg::CFG_STARTUP_ADDRESS) begin
				state_q.address_value <= cfg.data[7:0];
			end
			if (cfg_wr && cfg.index == i2cgc_pkg::CFG_STARTUP_KEY) begin
				state_q.key_value <= cfg.data;
			end
		end
	end

endmodule

// File: rtl/core/i2c_slave_general_call_handler_core.sv
// I2C target event handler with general-call commands.
// Channels: evt takes one bus event (stop, received byte or transmit
// request) per transaction; res returns exactly one result per event with
// the reload, nack and register access flags and the current own address
// and project key; cfg writes startup_address (index 0) or startup_key
// (index 1), which load the live address or key directly.
// The event is held in the input register, and its result is decoded from it
// and registered in the result register once that register is free or being drained.
// Throughput: one event per cycle while res is not stalled, as the state
// register is updated from the event decode logic on every advance.
// Reset clears bus phase, command, byte count, pointer, pending flag,
// address and key to zero and empties both pipeline registers.
// When res is stalled the result register holds, the input register
// still takes one more event, and evt.ready then drops until res drains.
// cfg is always ready; write it only while no event is in flight.
module i2c_slave_general_call_handler_core (
	input  logic        clk,
	input  logic        arst_n,
	i2cgc_evt_if.sink   evt,
	i2cgc_res_if.source res,
	i2cgc_cfg_if.sink   cfg
);

	i2cgc_pkg::state_t st;
	i2cgc_pkg::state_t nxt;
	i2cgc_pkg::event_t evt_s1;
	i2cgc_pkg::result_t res_comb;

	// pipeline and state registers
	i2cgc_core_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.evt      (evt),
		.res      (res),
		.cfg      (cfg),
		.st       (st),
		.evt_s1   (evt_s1),
		.nxt      (nxt),
		.res_comb (res_comb)
	);

	// per-event decode
	i2cgc_event_logic u_logic (
		.st  (st),
		.evt (evt_s1),
		.nxt (nxt),
		.res (res_comb)
	);

endmodule

// File: tb/tb_i2c_slave_general_call_handler_core.sv
module tb_i2c_slave_general_call_handler_core;

	// event code with no meaning to the target
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n;

	i2cgc_evt_if evt_ch ();
	i2cgc_res_if res_ch ();
	i2cgc_cfg_if cfg_ch ();

	i2c_slave_general_call_handler_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.evt    (evt_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	// bus events waiting to be sent and results the target still owes
	i2cgc_pkg::event_t pending_events[$];
	i2cgc_pkg::result_t awaited_results[$];
	int queued_count = 0;
	int mismatches = 0;
	int cycle_count = 0;
	logic [15:0] phase_key;

	// shadow of the target state
	logic [1:0] phase;
	logic [7:0] command;
	logic [1:0] gc_count;
	logic [7:0] key_low;
	logic addr_change_pending;
	logic [7:0] own_addr;
	logic [15:0] own_key;
	logic signed [7:0] reg_ptr;

	// handshake pacing
	int send_gap = 0;
	bit send_calm = 1'b0;
	int take_hold = 0;
	bit take_calm = 1'b0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int draw_wait(input bit calm);
		return calm ? 0 : int'($urandom_range(0, 19));
	endfunction

	// one byte of a general-call transfer, returns the nack answer
	function automatic logic general_call_byte(input logic [7:0] b, input logic first,
			input logic won);
		logic [1:0] prior;
		logic refuse;
		refuse = 1'b0;
		if (first) begin
			gc_count = 2'd1;
			command = b;
			if (b == i2cgc_pkg::CMD_RESET_ALL) begin
				own_addr = 8'h00;
				addr_change_pending = 1'b1;
				own_key = 16'h0000;
			end
		end else begin
			prior = gc_count;
			if (gc_count != i2cgc_pkg::SEEN_MAX)
				gc_count = gc_count + 2'd1;
			case (command)
				i2cgc_pkg::CMD_NEW_ADDR: begin
					if (!addr_change_pending && own_addr != 8'h00)
						refuse = 1'b1;
					else if (prior >= 2'd2)
						refuse = 1'b0;
					else if (won) begin
						addr_change_pending = 1'b1;
						own_addr = b;
					end else
						refuse = 1'b1;
				end
				i2cgc_pkg::CMD_VERIFY_KEY: begin
					if (prior == 2'd1)
						key_low = b;
					else if (prior == 2'd2 && {b, key_low} != own_key) begin
						own_addr = 8'h00;
						addr_change_pending = 1'b1;
						own_key = {b, key_low};
					end
				end
				i2cgc_pkg::CMD_UPDATE_KEY: begin
					if (prior == 2'd1)
						key_low = b;
					else if (prior == 2'd2)
						own_key = {b, key_low};
				end
				default: ;
			endcase
		end
		return refuse;
	endfunction

	// next target state and the result of one bus event
	function automatic i2cgc_pkg::result_t target_response(input i2cgc_pkg::event_t ev);
		i2cgc_pkg::result_t r;
		logic first;
		r = '0;
		case (ev.operation)
			i2cgc_pkg::OP_STOP: begin
				phase = i2cgc_pkg::PHASE_IDLE;
				if (addr_change_pending) begin
					addr_change_pending = 1'b0;
					r.address_reload = 1'b1;
				end
			end
			i2cgc_pkg::OP_RX_BYTE: begin
				first = (phase == i2cgc_pkg::PHASE_IDLE);
				phase = first ? i2cgc_pkg::PHASE_RX_FIRST : i2cgc_pkg::PHASE_RX;
				if (ev.general_call)
					r.nack = general_call_byte(ev.rx_byte, first, ev.arbitration_won);
				else if (first)
					reg_ptr = ev.rx_byte;
				else begin
					r.reg_write = 1'b1;
					r.reg_target = (reg_ptr >= 8'sd2);
					r.reg_index = reg_ptr;
					r.reg_data = ev.rx_byte;
				end
			end
			i2cgc_pkg::OP_TX_REQ: begin
				phase = i2cgc_pkg::PHASE_TX;
				r.read_request = 1'b1;
				r.reg_target = (reg_ptr >= 8'sd2);
				r.reg_index = reg_ptr;
			end
			default: ;
		endcase
		r.own_address = own_addr;
		r.project_key = own_key;
		return r;
	endfunction

	function automatic void add_event(input logic [1:0] op, input logic [7:0] b,
			input logic gc, input logic won);
		i2cgc_pkg::event_t e;
		e.operation = op;
		e.rx_byte = b;
		e.general_call = gc;
		e.arbitration_won = won;
		pending_events.push_back(e);
		queued_count++;
	endfunction

	function automatic logic [7:0] pick_pointer();
		case ($urandom_range(0, 5))
			0: return 8'h00;
			1: return 8'h01;
			2: return 8'h02;
			3: return 8'h7F;
			4: return 8'h80;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic void note_field(input string field, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch on %s: expected %h, got %h", field, want, got);
		end
	endfunction

	task automatic check_result(input i2cgc_pkg::result_t got);
		i2cgc_pkg::result_t want;
		if (awaited_results.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result %h arrived with nothing awaited", got);
		end else begin
			want = awaited_results.pop_front();
			note_field("address_reload", {15'd0, want.address_reload},
				{15'd0, got.address_reload});
			note_field("own_address", {8'h00, want.own_address}, {8'h00, got.own_address});
			note_field("nack", {15'd0, want.nack}, {15'd0, got.nack});
			note_field("project_key", want.project_key, got.project_key);
			note_field("reg_write", {15'd0, want.reg_write}, {15'd0, got.reg_write});
			note_field("read_request", {15'd0, want.read_request},
				{15'd0, got.read_request});
			note_field("reg_target", {15'd0, want.reg_target}, {15'd0, got.reg_target});
			note_field("reg_index", {8'h00, want.reg_index}, {8'h00, got.reg_index});
			note_field("reg_data", {8'h00, want.reg_data}, {8'h00, got.reg_data});
		end
	endtask

	// configuration write, only while the target is idle
	task automatic write_register(input logic [i2cgc_pkg::CFG_IDX_W-1:0] idx,
			input logic [i2cgc_pkg::CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		cfg_ch.valid <= 1'b1;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		if (idx == i2cgc_pkg::CFG_STARTUP_ADDRESS)
			own_addr = value[7:0];
		else if (idx == i2cgc_pkg::CFG_STARTUP_KEY)
			own_key = value;
	endtask

	task automatic reconfigure(input logic [7:0] addr, input logic [15:0] key);
		write_register(i2cgc_pkg::CFG_STARTUP_ADDRESS, {8'h00, addr});
		write_register(i2cgc_pkg::CFG_STARTUP_KEY, key);
		phase_key = key;
	endtask

	// hold the sender until every result is back, then let the pipeline settle
	task automatic wait_drained();
		do @(negedge clk);
		while (pending_events.size() != 0 || evt_ch.valid || awaited_results.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	// mostly well-formed transfers with random content, some noise and missing stops
	task automatic queue_random_traffic(input int amount);
		int start;
		int n;
		int i;
		logic [7:0] cmd;
		logic [7:0] b;
		logic [15:0] k;
		start = queued_count;
		while (queued_count - start < amount) begin
			case ($urandom_range(0, 9))
				0, 1: begin
					add_event(i2cgc_pkg::OP_RX_BYTE, pick_pointer(), 1'b0,
						1'($urandom_range(0, 1)));
					n = $urandom_range(0, 4);
					for (i = 0; i < n; i++)
						add_event(i2cgc_pkg::OP_RX_BYTE, 8'($urandom_range(0, 255)), 1'b0,
							1'($urandom_range(0, 1)));
					if ($urandom_range(0, 2) == 0)
						add_event(i2cgc_pkg::OP_TX_REQ, 8'($urandom_range(0, 255)),
							1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				end
				2: begin
					if ($urandom_range(0, 2) != 0)
						add_event(i2cgc_pkg::OP_RX_BYTE, pick_pointer(), 1'b0,
							1'($urandom_range(0, 1)));
					n = $urandom_range(1, 3);
					for (i = 0; i < n; i++)
						add_event(i2cgc_pkg::OP_TX_REQ, 8'($urandom_range(0, 255)),
							1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				end
				3, 4, 5, 6, 7: begin
					case ($urandom_range(0, 5))
						0, 4: cmd = i2cgc_pkg::CMD_NEW_ADDR;
						1: cmd = i2cgc_pkg::CMD_RESET_ALL;
						2: cmd = i2cgc_pkg::CMD_VERIFY_KEY;
						3: cmd = i2cgc_pkg::CMD_UPDATE_KEY;
						default: cmd = 8'($urandom_range(0, 255));
					endcase
					case ($urandom_range(0, 3))
						0: k = 16'h0000;
						1: k = 16'hFFFF;
						2: k = phase_key;
						default: k = 16'($urandom_range(0, 65535));
					endcase
					add_event(i2cgc_pkg::OP_RX_BYTE, cmd, 1'b1, 1'($urandom_range(0, 1)));
					n = $urandom_range(0, 4);
					for (i = 1; i <= n; i++) begin
						if (i == 1)
							b = k[7:0];
						else if (i == 2)
							b = k[15:8];
						else
							b = 8'($urandom_range(0, 255));
						add_event(i2cgc_pkg::OP_RX_BYTE, b, $urandom_range(0, 15) != 0,
							$urandom_range(0, 3) != 0);
					end
				end
				default: begin
					n = $urandom_range(1, 3);
					for (i = 0; i < n; i++)
						add_event(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
							1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				end
			endcase
			if ($urandom_range(0, 9) != 0)
				add_event(i2cgc_pkg::OP_STOP, 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		end
	endtask

	// event driver
	always @(posedge clk) begin
		if (!arst_n) begin
			evt_ch.valid <= 1'b0;
		end else begin
			if (evt_ch.valid && evt_ch.ready)
				awaited_results.push_back(target_response(evt_ch.data));
			if (!evt_ch.valid || evt_ch.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					evt_ch.valid <= 1'b0;
				end else if (pending_events.size() != 0) begin
					evt_ch.valid <= 1'b1;
					evt_ch.data <= pending_events.pop_front();
					if ($urandom_range(0, 24) == 0)
						send_calm = !send_calm;
					send_gap = draw_wait(send_calm);
				end else begin
					evt_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			take_hold = 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				check_result(res_ch.data);
				if ($urandom_range(0, 24) == 0)
					take_calm = !take_calm;
				take_hold = draw_wait(take_calm);
			end else if (res_ch.valid && take_hold > 0) begin
				take_hold--;
			end
			res_ch.ready <= (take_hold == 0);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		evt_ch.valid = 1'b0;
		evt_ch.data = '0;
		res_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		phase = i2cgc_pkg::PHASE_IDLE;
		command = 8'h00;
		gc_count = 2'd0;
		key_low = 8'h00;
		addr_change_pending = 1'b0;
		own_addr = 8'h00;
		own_key = 16'h0000;
		reg_ptr = 8'sd0;
		phase_key = 16'h0000;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		reconfigure(8'h3C, 16'h1234);
		// general-call byte after a transmit request, count never set
		add_event(i2cgc_pkg::OP_TX_REQ, 8'h00, 1'b0, 1'b0);
		add_event(i2cgc_pkg::OP_RX_BYTE, i2cgc_pkg::CMD_NEW_ADDR, 1'b1, 1'b1);
		add_event(OP_UNUSED, 8'hA5, 1'b1, 1'b1);
		add_event(i2cgc_pkg::OP_STOP, 8'h00, 1'b0, 1'b0);
		// addressed writes and read, pointer at the top of the positive range
		add_event(i2cgc_pkg::OP_RX_BYTE, 8'h7F, 1'b0, 1'b0);
		add_event(i2cgc_pkg::OP_RX_BYTE, 8'hFF, 1'b0, 1'b0);
		add_event(i2cgc_pkg::OP_RX_BYTE, 8'h00, 1'b0, 1'b0);
		add_event(i2cgc_pkg::OP_TX_REQ, 8'hFF, 1'b1, 1'b1);
		add_event(i2cgc_pkg::OP_STOP, 8'hFF, 1'b1, 1'b1);
		// negative pointer goes to system registers
		add_event(i2cgc_pkg::OP_RX_BYTE, 8'h80, 1'b0, 1'b0);
		add_event(i2cgc_pkg::OP_TX_REQ, 8'h00, 1'b0, 1'b0);
		add_event(i2cgc_pkg::OP_RX_BYTE, 8'h5C, 1'b0, 1'b0);
		add_event(i2cgc_pkg::OP_STOP, 8'h00, 1'b0, 1'b0);
		// reset-all, later bytes of it ignored
		add_event(i2cgc_pkg::OP_RX_BYTE, i2cgc_pkg::CMD_RESET_ALL, 1'b1, 1'b0);
		add_event(i2cgc_pkg::OP_RX_BYTE, 8'hEE, 1'b1, 1'b0);
		add_event(i2cgc_pkg::OP_STOP, 8'h00, 1'b0, 1'b0);
		// lost arbitration, then a byte beyond the address
		add_event(i2cgc_pkg::OP_RX_BYTE, i2cgc_pkg::CMD_NEW_ADDR, 1'b1, 1'b0);
		add_event(i2cgc_pkg::OP_RX_BYTE, 8'h5A, 1'b1, 1'b0);
		add_event(i2cgc_pkg::OP_RX_BYTE, 8'h33, 1'b1, 1'b1);
		add_event(i2cgc_pkg::OP_STOP, 8'h00, 1'b0, 1'b0);
		// won arbitration, address applied on stop
		add_event(i2cgc_pkg::OP_RX_BYTE, i2cgc_pkg::CMD_NEW_ADDR, 1'b1, 1'b0);
		add_event(i2cgc_pkg::OP_RX_BYTE, 8'h5A, 1'b1, 1'b1);
		add_event(i2cgc_pkg::OP_STOP, 8'h00, 1'b0, 1'b0);
		// new address while one is held
		add_event(i2cgc_pkg::OP_RX_BYTE, i2cgc_pkg::CMD_NEW_ADDR, 1'b1, 1'b1);
		add_event(i2cgc_pkg::OP_RX_BYTE, 8'h21, 1'b1, 1'b1);
		add_event(i2cgc_pkg::OP_STOP, 8'h00, 1'b0, 1'b0);
		wait_drained();

		reconfigure(8'hFF, 16'hFFFF);
		// verify with a matching key, then a mismatch plus an extra byte
		add_event(i2cgc_pkg::OP_RX_BYTE, i2cgc_pkg::CMD_VERIFY_KEY, 1'b1, 1'b0);
		add_event(i2cgc_pkg::OP_RX_BYTE, 8'hFF, 1'b1, 1'b0);
		add_event(i2cgc_pkg::OP_RX_BYTE, 8'hFF, 1'b1, 1'b0);
		add_event(i2cgc_pkg::OP_STOP, 8'h00, 1'b0, 1'b0);
		add_event(i2cgc_pkg::OP_RX_BYTE, i2cgc_pkg::CMD_VERIFY_KEY, 1'b1, 1'b1);
		add_event(i2cgc_pkg::OP_RX_BYTE, 8'h34, 1'b1, 1'b1);
		add_event(i2cgc_pkg::OP_RX_BYTE, 8'h12, 1'b1, 1'b1);
		add_event(i2cgc_pkg::OP_RX_BYTE, 8'h99, 1'b1, 1'b1);
		add_event(i2cgc_pkg::OP_STOP, 8'h00, 1'b0, 1'b0);
		// update with an extra byte
		add_event(i2cgc_pkg::OP_RX_BYTE, i2cgc_pkg::CMD_UPDATE_KEY, 1'b1, 1'b0);
		add_event(i2cgc_pkg::OP_RX_BYTE, 8'h00, 1'b1, 1'b0);
		add_event(i2cgc_pkg::OP_RX_BYTE, 8'h80, 1'b1, 1'b0);
		add_event(i2cgc_pkg::OP_RX_BYTE, 8'h77, 1'b1, 1'b0);
		add_event(i2cgc_pkg::OP_STOP, 8'h00, 1'b0, 1'b0);
		// unknown command
		add_event(i2cgc_pkg::OP_RX_BYTE, 8'h7E, 1'b1, 1'b1);
		add_event(i2cgc_pkg::OP_RX_BYTE, 8'h01, 1'b1, 1'b1);
		add_event(i2cgc_pkg::OP_STOP, 8'h00, 1'b0, 1'b0);
		queue_random_traffic(130);
		wait_drained();

		reconfigure(8'h00, 16'h0000);
		queue_random_traffic(70);
		wait_drained();
		queue_random_traffic(70);
		wait_drained();

		reconfigure(8'($urandom_range(1, 254)), 16'($urandom_range(0, 65535)));
		queue_random_traffic(130);
		wait_drained();

		if (awaited_results.size() != 0)
			mismatches++;
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
